// ===== hw/rtl/uac_pkg.sv =====
// Shared constants, widths and handshake structs of the unbiased autocorrelation unit.
package uac_pkg;

  // Capacity and sample precision.
  localparam int MAX_SAMPLES = 32;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths of the channels.
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 6;
  localparam int LAG_W    = 32;

  // Derived internal widths.
  localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int POS_IW  = CNT_W + 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int MAG_W   = ACC_W - 1;
  localparam int STEP_W  = $clog2(MAG_W + 1);

  // Divide request: a start pulse with its operands.
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  // Divide response: a done pulse and the quotient, truncated toward zero.
  typedef struct packed {
    logic                    done;
    logic signed [LAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/uac_channels.sv =====
// Valid/ready channel interfaces for samples in and lag values out.
interface uac_in_if;
  import uac_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface uac_out_if;
  import uac_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        lag_position;
  logic signed [LAG_W-1:0] lag_value;
  logic                    overflowed;
  logic                    last_lag;

  modport source (output valid, output lag_position, output lag_value, output overflowed,
                  output last_lag, input ready);
  modport sink (input valid, input lag_position, input lag_value, input overflowed,
                input last_lag, output ready);
endinterface

// ===== hw/rtl/uac_divider.sv =====
// Bit-serial signed divider: correlation sum over overlap length, truncating toward zero.
module uac_divider (
  input  logic              clk,
  input  logic              rst,
  input  uac_pkg::div_req_t req,
  output uac_pkg::div_rsp_t rsp
);
  import uac_pkg::*;

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic [CNT_W-1:0]        rem;
  logic [MAG_W-1:0]        quo;
  logic [CNT_W-1:0]        dvsr;
  logic                    neg;
  logic                    done;
  logic [CNT_W:0]          trial;
  logic                    fits;
  logic signed [ACC_W-1:0] abs_dividend;
  logic signed [LAG_W-1:0] quo_lag;

  // Magnitude of the dividend at start.
  assign abs_dividend = req.dividend[ACC_W-1] ? -req.dividend : req.dividend;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem, quo[MAG_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= abs_dividend[MAG_W-1:0];
      dvsr <= req.divisor;
      neg  <= req.dividend[ACC_W-1];
    end else if (busy) begin
      rem <= fits ? CNT_W'(trial - {1'b0, dvsr}) : CNT_W'(trial);
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  // Restore the sign; the quotient always fits the lag width.
  assign quo_lag      = LAG_W'(quo);
  assign rsp.done     = done;
  assign rsp.quotient = neg ? -quo_lag : quo_lag;

endmodule

// ===== hw/rtl/unbiased_autocorrelation_unit.sv =====
// Unbiased autocorrelation unit: collects a sequence of samples, then streams 2n-1 lag averages.
// Samples are taken one per cycle while the unit collects; up to MAX_SAMPLES are kept, and
// further samples are dropped and reported through the overflowed bit of every result of the
// run. The request with last_sample set closes the sequence of n samples; the unit then drops
// ready and works through each overlap i = 0..n-1 with one shared multiplier, one product per
// cycle through the memory read and multiply pipeline, followed by a bit-serial divide of the
// sum by i+1. The 2n-1 results then leave one at a time while the sink is ready, each read from
// the lag memory before it is offered, positions n..2n-2 mirroring the first half. After the last
// result the unit collects a new sequence.
module unbiased_autocorrelation_unit (
  input  logic      clk,
  input  logic      rst,
  uac_in_if.sink    samples,
  uac_out_if.source lags
);
  import uac_pkg::*;

  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_MAC     = 5'b00010,
    S_DIV     = 5'b00100,
    S_FETCH   = 5'b01000,
    S_SHOW    = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [IDX_W-1:0] lag_i;
  logic [IDX_W-1:0] term_j;
  logic             issue;
  logic             v1;
  logic             v2;
  logic [POS_IW-1:0] pos;

  logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  logic signed [LAG_W-1:0] lag_mem [MAX_SAMPLES];
  logic signed [LAG_W-1:0] lag_rd;

  logic              in_acc;
  logic              out_acc;
  logic              store_ok;
  logic [IDX_W-1:0]  addr_b;
  logic              mac_idle;
  logic [POS_IW-1:0] last_pos;
  logic [IDX_W-1:0]  lag_raddr;
  logic              last_lag_i;
  logic              div_start;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Handshake decode.
  assign samples.ready = (state == S_COLLECT);
  assign in_acc        = samples.valid && samples.ready;
  assign out_acc       = lags.valid && lags.ready;
  assign store_ok      = (count < CNT_W'(MAX_SAMPLES));

  // Partner index of term j in overlap i: n-1-i+j.
  assign addr_b   = IDX_W'(count - CNT_W'(1) - CNT_W'(lag_i) + CNT_W'(term_j));
  assign mac_idle = !issue && !v1 && !v2;

  // Output sequencing: positions past n-1 read the mirrored lag.
  assign last_pos   = POS_IW'({count, 1'b0}) - POS_IW'(2);
  assign lag_raddr  = (pos < POS_IW'(count)) ? IDX_W'(pos) : IDX_W'(last_pos - pos);
  assign last_lag_i = (lag_i == IDX_W'(count - CNT_W'(1)));

  // Sample memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      sample_mem[IDX_W'(count)] <= samples.sample[SAMPLE_BITS-1:0];
    end
    rd_a <= sample_mem[term_j];
    rd_b <= sample_mem[addr_b];
  end

  // Lag memory: written by the divider, read with a registered port for output.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      lag_mem[lag_i] <= div_rsp.quotient;
    end
    lag_rd <= lag_mem[lag_raddr];
  end

  // Shared multiplier and accumulator.
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
    if (state == S_DIV && div_rsp.done) begin
      acc <= '0;
    end else if (state == S_COLLECT) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      count     <= '0;
      ovf       <= 1'b0;
      lag_i     <= '0;
      term_j    <= '0;
      issue     <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      pos       <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      v1        <= issue;
      v2        <= v1;
      case (state)
        S_COLLECT: begin
          if (in_acc) begin
            if (store_ok) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (samples.last_sample) begin
              state  <= S_MAC;
              lag_i  <= '0;
              term_j <= '0;
              issue  <= 1'b1;
            end
          end
        end
        S_MAC: begin
          if (issue) begin
            if (term_j == lag_i) begin
              issue <= 1'b0;
            end else begin
              term_j <= term_j + IDX_W'(1);
            end
          end else if (mac_idle) begin
            state     <= S_DIV;
            div_start <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (last_lag_i) begin
              state <= S_FETCH;
              pos   <= '0;
            end else begin
              state  <= S_MAC;
              lag_i  <= lag_i + IDX_W'(1);
              term_j <= '0;
              issue  <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (out_acc) begin
            if (pos == last_pos) begin
              state <= S_COLLECT;
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              state <= S_FETCH;
              pos   <= pos + POS_IW'(1);
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  // Divider request.
  assign div_req.start    = div_start;
  assign div_req.dividend = acc;
  assign div_req.divisor  = CNT_W'(lag_i) + CNT_W'(1);

  uac_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Result request.
  assign lags.valid        = (state == S_SHOW);
  assign lags.lag_position = POS_W'(pos);
  assign lags.lag_value    = lag_rd;
  assign lags.overflowed   = ovf;
  assign lags.last_lag     = (pos == last_pos);

  // The input side is never open while a result is offered.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !lags.valid)
    else $error("sample ready while a result is offered");

  // The sample count never passes capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");

  // The final result of a run empties the sequence.
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (out_acc && lags.last_lag) |=> (count == '0 && !ovf && samples.ready))
    else $error("sequence not cleared after final result");

  // A divide finishes only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divide finished outside the divide step");

  // Products are issued only while working on an overlap.
  a_mac_state: assert property (@(posedge clk) disable iff (rst)
    issue |-> state == S_MAC)
    else $error("product issued outside the accumulate step");

endmodule
